@@ rtl/core/backlight_fade_controller_unit_defines.svh @@
// assertion macros shared by the backlight fade controller rtl
`ifndef BACKLIGHT_FADE_CONTROLLER_UNIT_DEFINES_SVH
`define BACKLIGHT_FADE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define BFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("bfc assertion failed");

// property checked on every edge, reset included
`define BFC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bfc assertion failed");

`else

`define BFC_ASSERT(lbl, clk, rst_n, prop)
`define BFC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/bfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

    // field widths
    localparam int W_OPCODE   = 4;
    localparam int W_LEVEL    = 16;
    localparam int W_HOLD     = 20;
    localparam int W_INTERVAL = 8;
    localparam int W_HELD     = 3;
    localparam int W_MODE     = 2;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 20;

    // default parameter values
    localparam int P_FULL_SCALE   = 65535;
    localparam int P_WINDOW_DEPTH = 5;
    localparam int P_FADE_DIVISOR = 20;

    // register reset values
    localparam logic [W_LEVEL-1:0]    RST_USER_LEVEL = 16'd65535;
    localparam logic [W_HOLD-1:0]     RST_HOLD_TICKS = 20'd3000;
    localparam logic [W_INTERVAL-1:0] RST_INTERVAL   = 8'd25;

    // most buttons that may be held at once
    localparam logic [W_HELD-1:0] MAX_HELD = 3'd4;

    typedef enum logic [W_OPCODE-1:0] {
        OP_PRESS         = 4'd0,
        OP_RELEASE       = 4'd1,
        OP_INTERACT      = 4'd2,
        OP_FORCE         = 4'd3,
        OP_REQUEST       = 4'd4,
        OP_RESET_USER    = 4'd5,
        OP_RESET_TIMED   = 4'd6,
        OP_TOGGLE_ENABLE = 4'd7,
        OP_TOGGLE_AMBIENT = 4'd8,
        OP_ALLOW         = 4'd9,
        OP_TICK          = 4'd10,
        OP_SAMPLE        = 4'd11
    } t_opcode;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_USER_LEVEL   = 3'd0,
        CFG_HOLD_TICKS   = 3'd1,
        CFG_FADE_INTERVAL = 3'd2,
        CFG_DYNAMIC_MODE = 3'd3,
        CFG_DARK_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_opcode              opcode;
        logic                 flag;
        logic                 ambient_bright;
        logic                 power_save;
        logic [W_LEVEL-1:0]   ambient_level;
    } t_item;

    typedef struct packed {
        logic [W_LEVEL-1:0]   brightness;
        logic [W_MODE-1:0]    mode;
        logic                 level_changed;
        logic                 count_error;
    } t_result;

    typedef struct packed {
        logic [W_LEVEL-1:0]    user_level;
        logic [W_HOLD-1:0]     hold_ticks;
        logic [W_INTERVAL-1:0] fade_interval;
        logic                  dynamic_mode;
        logic [W_LEVEL-1:0]    dark_limit;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/bfc_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bfc_item_if;

    logic                          valid;
    logic                          ready;
    logic [bfc_pkg::W_OPCODE-1:0]  opcode;
    logic                          flag;
    logic                          ambient_bright;
    logic                          power_save;
    logic [bfc_pkg::W_LEVEL-1:0]   ambient_level;

    modport source (
        output valid, opcode, flag, ambient_bright, power_save, ambient_level,
        input  ready
    );

    modport sink (
        input  valid, opcode, flag, ambient_bright, power_save, ambient_level,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/bfc_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bfc_result_if;

    logic                          valid;
    logic                          ready;
    logic [bfc_pkg::W_LEVEL-1:0]   brightness;
    logic [bfc_pkg::W_MODE-1:0]    mode;
    logic                          level_changed;
    logic                          count_error;

    modport source (
        output valid, brightness, mode, level_changed, count_error,
        input  ready
    );

    modport sink (
        input  valid, brightness, mode, level_changed, count_error,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/backlight_fade_controller_unit.sv @@
`timescale 1ns / 1ps
// backlight fade controller
// events enter on the item channel (valid/ready): button press and release,
// user requests, setting toggles, allow changes, ambient samples and 1 ms
// ticks. every accepted item gives exactly one beat on the result channel
// carrying brightness, mode, level_changed and count_error.
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must only write them while idle; the block itself does not enforce it.
// a write takes effect at the edge it is presented. an item is held in the
// input register; its result is computed by the controller logic and lands
// in the result register. throughput: one item per cycle while results are
// taken; the controller state is updated in the same cycle the result
// register is loaded, so back-to-back items see it. a stalled receiver holds
// the result register; the input register still takes one more item, after
// which ready drops until the result is taken. reset (synchronous, active
// low) puts the light off at level zero, clears the button count, the forced,
// allow and gate flags and sample window, sets enable, loads register defaults.
`default_nettype none

module backlight_fade_controller_unit #(
    parameter int FULL_SCALE   = bfc_pkg::P_FULL_SCALE,
    parameter int WINDOW_DEPTH = bfc_pkg::P_WINDOW_DEPTH,
    parameter int FADE_DIVISOR = bfc_pkg::P_FADE_DIVISOR
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bfc_item_if.sink                            i_item,
    bfc_result_if.source                        o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [bfc_pkg::W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [bfc_pkg::W_CFG_DATA-1:0] i_cfg_data
);

    logic              r_item_vld;
    bfc_pkg::t_item    r_item;
    logic              r_res_vld;
    bfc_pkg::t_result  r_res;
    bfc_pkg::t_cfg     r_cfg;
    bfc_pkg::t_result  w_res;
    logic              w_adv;
    logic              w_take;
    logic              w_dark;

    // item moves on when the result register is free or being emptied
    assign w_adv  = r_item_vld && (!r_res_vld || o_result.ready);
    assign w_take = i_item.valid && i_item.ready;
    assign i_item.ready = !r_item_vld || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (w_take) begin
            r_item_vld <= 1'b1;
        end else if (w_adv) begin
            r_item_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.opcode         <= bfc_pkg::t_opcode'(i_item.opcode);
            r_item.flag           <= i_item.flag;
            r_item.ambient_bright <= i_item.ambient_bright;
            r_item.power_save     <= i_item.power_save;
            r_item.ambient_level  <= i_item.ambient_level;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.user_level    <= bfc_pkg::RST_USER_LEVEL;
            r_cfg.hold_ticks    <= bfc_pkg::RST_HOLD_TICKS;
            r_cfg.fade_interval <= bfc_pkg::RST_INTERVAL;
            r_cfg.dynamic_mode  <= 1'b0;
            r_cfg.dark_limit    <= '0;
        end else if (i_cfg_we) begin
            case (bfc_pkg::t_cfg_idx'(i_cfg_idx))
                bfc_pkg::CFG_USER_LEVEL: begin
                    r_cfg.user_level <= i_cfg_data[bfc_pkg::W_LEVEL-1:0];
                end
                bfc_pkg::CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_cfg_data[bfc_pkg::W_HOLD-1:0];
                end
                bfc_pkg::CFG_FADE_INTERVAL: begin
                    r_cfg.fade_interval <= i_cfg_data[bfc_pkg::W_INTERVAL-1:0];
                end
                bfc_pkg::CFG_DYNAMIC_MODE: begin
                    r_cfg.dynamic_mode <= i_cfg_data[0];
                end
                bfc_pkg::CFG_DARK_LIMIT: begin
                    r_cfg.dark_limit <= i_cfg_data[bfc_pkg::W_LEVEL-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ambient sample window and dark-zone test
    bfc_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_adv && (r_item.opcode == bfc_pkg::OP_SAMPLE)),
        .i_sample (r_item.ambient_level),
        .i_limit  (r_cfg.dark_limit),
        .o_dark   (w_dark)
    );

    // mode, level and timing control
    bfc_fsm #(
        .FULL_SCALE   (FULL_SCALE),
        .FADE_DIVISOR (FADE_DIVISOR)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_dark   (w_dark),
        .o_res    (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_adv) begin
            r_res_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid         = r_res_vld;
    assign o_result.brightness    = r_res.brightness;
    assign o_result.mode          = r_res.mode;
    assign o_result.level_changed = r_res.level_changed;
    assign o_result.count_error   = r_res.count_error;

endmodule

`default_nettype wire

@@ rtl/core/bfc_window.sv @@
`timescale 1ns / 1ps
`include "backlight_fade_controller_unit_defines.svh"
`default_nettype none

module bfc_window #(
    parameter int WINDOW_DEPTH = bfc_pkg::P_WINDOW_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_shift,
    input  wire logic [bfc_pkg::W_LEVEL-1:0] i_sample,
    input  wire logic [bfc_pkg::W_LEVEL-1:0] i_limit,
    output logic                             o_dark
);

    localparam int FW = $clog2(WINDOW_DEPTH + 1);

    logic [bfc_pkg::W_LEVEL-1:0] r_win [WINDOW_DEPTH];
    logic [FW-1:0]               r_fill;
    logic [WINDOW_DEPTH-1:0]     w_ok;

    // sample shift line, newest at the front
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= i_sample;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // fill count saturates at the window depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_shift && (r_fill != FW'(WINDOW_DEPTH))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // per-tap dark test, empty taps do not count
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            w_ok[i] = (FW'(i) >= r_fill) || (r_win[i] <= i_limit);
        end
    end

    assign o_dark = (r_fill != '0) && (&w_ok);

    `BFC_ASSERT(a_fill_after_shift, i_clk, i_rst_n, i_shift |=> (r_fill != '0))
    `BFC_ASSERT(a_fill_bound, i_clk, i_rst_n, $past(r_fill) == FW'(WINDOW_DEPTH) |-> r_fill == FW'(WINDOW_DEPTH))

endmodule

`default_nettype wire

@@ rtl/core/bfc_fsm.sv @@
`timescale 1ns / 1ps
`include "backlight_fade_controller_unit_defines.svh"
`default_nettype none

module bfc_fsm #(
    parameter int FULL_SCALE   = bfc_pkg::P_FULL_SCALE,
    parameter int FADE_DIVISOR = bfc_pkg::P_FADE_DIVISOR
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire bfc_pkg::t_item   i_item,
    input  wire bfc_pkg::t_cfg    i_cfg,
    input  wire logic             i_dark,
    output bfc_pkg::t_result      o_res
);

    localparam int WL = bfc_pkg::W_LEVEL;
    localparam int WH = bfc_pkg::W_HOLD;

    // fixed target levels
    localparam logic [WL-1:0] LP_LEVEL  = WL'(FULL_SCALE * 25 / 100);
    localparam logic [WL-1:0] DIM_LEVEL = WL'(FULL_SCALE * 10 / 100);

    // reciprocal for the fade step divide, exact over the full level range
    localparam int      DIV_SH  = WL + $clog2(FADE_DIVISOR);
    localparam longint  RECIP_L = ((longint'(1) << DIV_SH) + longint'(FADE_DIVISOR) - 1)
                                  / longint'(FADE_DIVISOR);
    localparam int      WR      = WL + 1;
    localparam logic [WR-1:0] RECIP = WR'(RECIP_L);
    localparam int      WP      = WL + WR;

    typedef enum logic [bfc_pkg::W_MODE-1:0] {
        MODE_ON     = 2'd0,
        MODE_TIMED  = 2'd1,
        MODE_FADING = 2'd2,
        MODE_OFF    = 2'd3
    } t_mode;

    t_mode                        r_mode, n_mode;
    logic [WL-1:0]                r_level, n_level;
    logic [WL-1:0]                r_step, n_step;
    logic [WH-1:0]                r_countdown, n_countdown;
    logic [bfc_pkg::W_HELD-1:0]   r_held, n_held;
    logic                         r_forced, n_forced;
    logic                         r_permitted, n_permitted;
    logic                         r_enabled, n_enabled;
    logic                         r_gate, n_gate;

    logic                         w_err;
    logic                         w_go;
    t_mode                        w_go_mode;
    logic                         w_ok_cur, w_ok_en, w_ok_gate;
    logic [WL-1:0]                w_target;
    logic [WP-1:0]                w_prod;
    logic [WL-1:0]                w_quot;
    logic [WL-1:0]                w_step_use;

    function automatic logic f_light_ok(
        input logic permitted,
        input logic enabled,
        input logic gate,
        input logic level_zero,
        input logic bright
    );
        return permitted && enabled && !(gate && level_zero && bright);
    endfunction

    // light allowed, with the current settings and with either toggle applied
    always_comb begin
        w_ok_cur  = f_light_ok(r_permitted, r_enabled, r_gate, r_level == '0,
                               i_item.ambient_bright);
        w_ok_en   = f_light_ok(r_permitted, !r_enabled, r_gate, r_level == '0,
                               i_item.ambient_bright);
        w_ok_gate = f_light_ok(r_permitted, r_enabled, !r_gate, r_level == '0,
                               i_item.ambient_bright);
    end

    // target intensity by precedence
    always_comb begin
        if (i_item.power_save) begin
            w_target = LP_LEVEL;
        end else if (i_cfg.dynamic_mode && i_dark) begin
            w_target = DIM_LEVEL;
        end else begin
            w_target = i_cfg.user_level;
        end
    end

    // fade step from the level at fade entry, never below one
    always_comb begin
        w_prod = WP'(r_level) * WP'(RECIP);
        w_quot = WL'(w_prod >> DIV_SH);
        if (r_mode == MODE_FADING) begin
            w_step_use = r_step;
        end else if (w_quot == '0) begin
            w_step_use = WL'(1);
        end else begin
            w_step_use = w_quot;
        end
    end

    // event decode: flag updates and the requested transition
    always_comb begin
        n_held      = r_held;
        n_forced    = r_forced;
        n_permitted = r_permitted;
        n_enabled   = r_enabled;
        n_gate      = r_gate;
        w_err       = 1'b0;
        w_go        = 1'b0;
        w_go_mode   = MODE_OFF;
        case (i_item.opcode)
            bfc_pkg::OP_PRESS: begin
                if (r_held == bfc_pkg::MAX_HELD) begin
                    n_held = '0;
                    w_err  = 1'b1;
                end else begin
                    n_held = r_held + 1'b1;
                end
                if (w_ok_cur) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_ON;
                end
            end
            bfc_pkg::OP_RELEASE: begin
                if (r_held == '0) begin
                    w_err = 1'b1;
                end else begin
                    n_held = r_held - 1'b1;
                end
                if ((n_held == '0) && (r_mode == MODE_ON) && !r_forced) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_TIMED;
                end
            end
            bfc_pkg::OP_INTERACT: begin
                if ((r_held == '0) && (r_mode != MODE_ON) && w_ok_cur) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_TIMED;
                end
            end
            bfc_pkg::OP_FORCE: begin
                n_forced = i_item.flag;
                if (i_item.flag) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_ON;
                end else if (r_held == '0) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_OFF;
                end
            end
            bfc_pkg::OP_REQUEST: begin
                n_forced = i_item.flag;
                if (i_item.flag) begin
                    if (w_ok_cur) begin
                        w_go      = 1'b1;
                        w_go_mode = MODE_ON;
                    end
                end else if (r_held == '0) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_OFF;
                end
            end
            bfc_pkg::OP_RESET_USER: begin
                if (r_forced) begin
                    n_forced = 1'b0;
                    if (r_held == '0) begin
                        w_go      = 1'b1;
                        w_go_mode = MODE_OFF;
                    end
                end
            end
            bfc_pkg::OP_RESET_TIMED: begin
                if (r_forced) begin
                    n_forced = 1'b0;
                    if (w_ok_cur) begin
                        w_go      = 1'b1;
                        w_go_mode = MODE_TIMED;
                    end
                end
            end
            bfc_pkg::OP_TOGGLE_ENABLE: begin
                n_enabled = !r_enabled;
                w_go      = 1'b1;
                w_go_mode = w_ok_en ? MODE_TIMED : MODE_OFF;
            end
            bfc_pkg::OP_TOGGLE_AMBIENT: begin
                n_gate    = !r_gate;
                w_go      = 1'b1;
                w_go_mode = (w_ok_gate && !i_item.ambient_bright) ? MODE_TIMED : MODE_OFF;
            end
            bfc_pkg::OP_ALLOW: begin
                if (r_permitted && !i_item.flag) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_OFF;
                end
                n_permitted = i_item.flag;
            end
            bfc_pkg::OP_TICK: begin
                if (r_countdown == WH'(1)) begin
                    w_go      = 1'b1;
                    w_go_mode = MODE_FADING;
                end
            end
            default: begin
            end
        endcase
    end

    // transition: level, step and countdown for the new mode
    always_comb begin
        n_mode  = r_mode;
        n_level = r_level;
        n_step  = r_step;
        if ((i_item.opcode == bfc_pkg::OP_TICK) && (r_countdown != '0)) begin
            n_countdown = r_countdown - 1'b1;
        end else begin
            n_countdown = r_countdown;
        end
        if (w_go) begin
            case (w_go_mode)
                MODE_ON: begin
                    n_mode      = MODE_ON;
                    n_level     = w_target;
                    n_countdown = '0;
                end
                MODE_TIMED: begin
                    n_mode      = MODE_TIMED;
                    n_level     = w_target;
                    n_countdown = (i_cfg.hold_ticks == '0) ? WH'(1) : i_cfg.hold_ticks;
                end
                MODE_FADING: begin
                    n_step = w_step_use;
                    if (r_level <= w_step_use) begin
                        n_mode      = MODE_OFF;
                        n_level     = '0;
                        n_countdown = '0;
                    end else begin
                        n_mode      = MODE_FADING;
                        n_level     = r_level - w_step_use;
                        n_countdown = (i_cfg.fade_interval == '0) ? WH'(1)
                                                                  : WH'(i_cfg.fade_interval);
                    end
                end
                default: begin
                    n_mode      = MODE_OFF;
                    n_level     = '0;
                    n_countdown = '0;
                end
            endcase
        end
    end

    // result of this beat
    always_comb begin
        o_res.brightness    = n_level;
        o_res.mode          = n_mode;
        o_res.level_changed = (n_level != r_level);
        o_res.count_error   = w_err;
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_level     <= '0;
            r_step      <= '0;
            r_countdown <= '0;
            r_held      <= '0;
            r_forced    <= 1'b0;
            r_permitted <= 1'b0;
            r_enabled   <= 1'b1;
            r_gate      <= 1'b0;
        end else if (i_adv) begin
            r_mode      <= n_mode;
            r_level     <= n_level;
            r_step      <= n_step;
            r_countdown <= n_countdown;
            r_held      <= n_held;
            r_forced    <= n_forced;
            r_permitted <= n_permitted;
            r_enabled   <= n_enabled;
            r_gate      <= n_gate;
        end
    end

    `BFC_ASSERT(a_off_is_dark, i_clk, i_rst_n, (r_mode == MODE_OFF) |-> (r_level == '0))
    `BFC_ASSERT(a_countdown_mode, i_clk, i_rst_n, (r_countdown != '0) |-> (r_mode == MODE_TIMED || r_mode == MODE_FADING))
    `BFC_ASSERT(a_fade_step_set, i_clk, i_rst_n, (r_mode == MODE_FADING) |-> (r_step != '0))
    `BFC_ASSERT_ALWAYS(a_reset_off, i_clk, $past(!i_rst_n) |-> (r_mode == MODE_OFF && r_countdown == '0))

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

import bfc_pkg::*;

// light states as reported on the result channel
typedef enum logic [W_MODE-1:0] {
    MODE_ON     = 2'd0,
    MODE_TIMED  = 2'd1,
    MODE_FADING = 2'd2,
    MODE_OFF    = 2'd3
} light_mode_e;

// one event beat; opcode kept as raw bits so the spare codes can be sent
typedef struct packed {
    logic [W_OPCODE-1:0] opcode;
    logic                flag;
    logic                ambient_bright;
    logic                power_save;
    logic [W_LEVEL-1:0]  ambient_level;
} event_item_t;

// tracks the controller state and the result beats still owed by the block
class fade_scoreboard;

    localparam int SAVE_PCT = 25;
    localparam int DIM_PCT  = 10;
    localparam int PERCENT  = 100;
    localparam logic [W_LEVEL-1:0] SAVE_LEVEL = W_LEVEL'(P_FULL_SCALE * SAVE_PCT / PERCENT);
    localparam logic [W_LEVEL-1:0] DIM_LEVEL = W_LEVEL'(P_FULL_SCALE * DIM_PCT / PERCENT);

    // register copies
    logic [W_LEVEL-1:0]    user_level;
    logic [W_HOLD-1:0]     hold_ticks;
    logic [W_INTERVAL-1:0] fade_interval;
    logic                  dynamic_mode;
    logic [W_LEVEL-1:0]    dark_limit;

    // controller state
    light_mode_e           mode_q;
    logic [W_LEVEL-1:0]    level_q;
    logic [W_LEVEL-1:0]    step_q;
    logic [W_HOLD-1:0]     countdown_q;
    logic [W_HELD-1:0]     held_q;
    bit                    forced_q;
    bit                    permitted_q;
    bit                    enabled_q;
    bit                    gate_q;
    logic [W_LEVEL-1:0]    window_q [P_WINDOW_DEPTH];
    int                    fill_q;
    bit                    bright_now;
    bit                    power_save_now;

    t_result               expected_levels [$];
    int                    errors;

    function new();
        user_level     = RST_USER_LEVEL;
        hold_ticks     = RST_HOLD_TICKS;
        fade_interval  = RST_INTERVAL;
        dynamic_mode   = 1'b0;
        dark_limit     = '0;
        mode_q         = MODE_OFF;
        level_q        = '0;
        step_q         = '0;
        countdown_q    = '0;
        held_q         = '0;
        forced_q       = 1'b0;
        permitted_q    = 1'b0;
        enabled_q      = 1'b1;
        gate_q         = 1'b0;
        foreach (window_q[i]) window_q[i] = '0;
        fill_q         = 0;
        bright_now     = 1'b0;
        power_save_now = 1'b0;
        errors         = 0;
    endfunction

    function void write_cfg(t_cfg_idx idx, logic [W_CFG_DATA-1:0] data);
        case (idx)
            CFG_USER_LEVEL:    user_level    = data[W_LEVEL-1:0];
            CFG_HOLD_TICKS:    hold_ticks    = data[W_HOLD-1:0];
            CFG_FADE_INTERVAL: fade_interval = data[W_INTERVAL-1:0];
            CFG_DYNAMIC_MODE:  dynamic_mode  = data[0];
            CFG_DARK_LIMIT:    dark_limit    = data[W_LEVEL-1:0];
            default: ;
        endcase
    endfunction

    function int outstanding();
        return expected_levels.size();
    endfunction

    // power save wins, then the dark zone over a non-empty window, then the user level
    function logic [W_LEVEL-1:0] target_intensity();
        bit dark;
        if (power_save_now)
            return SAVE_LEVEL;
        if (dynamic_mode && fill_q > 0) begin
            dark = 1'b1;
            for (int i = 0; i < fill_q; i++)
                if (window_q[i] > dark_limit)
                    dark = 1'b0;
            if (dark)
                return DIM_LEVEL;
        end
        return user_level;
    endfunction

    function bit light_allowed();
        if (!permitted_q || !enabled_q)
            return 1'b0;
        if (gate_q && level_q == '0 && bright_now)
            return 1'b0;
        return 1'b1;
    endfunction

    function void enter_mode(light_mode_e next);
        light_mode_e old;
        old = mode_q;
        mode_q = next;
        case (next)
            MODE_ON: begin
                level_q     = target_intensity();
                countdown_q = '0;
            end
            MODE_TIMED: begin
                level_q     = target_intensity();
                countdown_q = (hold_ticks == '0) ? W_HOLD'(1) : hold_ticks;
            end
            MODE_FADING: begin
                // step fixed on entry, never below one
                if (old != MODE_FADING) begin
                    step_q = level_q / W_LEVEL'(P_FADE_DIVISOR);
                    if (step_q == '0)
                        step_q = W_LEVEL'(1);
                end
                if (level_q <= step_q) begin
                    level_q     = '0;
                    mode_q      = MODE_OFF;
                    countdown_q = '0;
                end else begin
                    level_q     = level_q - step_q;
                    countdown_q = (fade_interval == '0) ? W_HOLD'(1) : W_HOLD'(fade_interval);
                end
            end
            default: begin
                level_q     = '0;
                countdown_q = '0;
            end
        endcase
    endfunction

    // apply one accepted event and queue the beat it must produce
    function void note_event(event_item_t ev);
        logic [W_LEVEL-1:0] prior;
        bit                 err;
        t_result            exp;
        prior          = level_q;
        err            = 1'b0;
        bright_now     = ev.ambient_bright;
        power_save_now = ev.power_save;
        case (ev.opcode)
            OP_PRESS: begin
                held_q = held_q + 1'b1;
                if (held_q > MAX_HELD) begin
                    held_q = '0;
                    err    = 1'b1;
                end
                if (light_allowed())
                    enter_mode(MODE_ON);
            end
            OP_RELEASE: begin
                if (held_q == '0)
                    err = 1'b1;
                else
                    held_q = held_q - 1'b1;
                if (held_q == '0 && mode_q == MODE_ON && !forced_q)
                    enter_mode(MODE_TIMED);
            end
            OP_INTERACT: begin
                if (held_q == '0 && mode_q != MODE_ON && light_allowed())
                    enter_mode(MODE_TIMED);
            end
            OP_FORCE: begin
                forced_q = ev.flag;
                if (ev.flag)
                    enter_mode(MODE_ON);
                else if (held_q == '0)
                    enter_mode(MODE_OFF);
            end
            OP_REQUEST: begin
                forced_q = ev.flag;
                if (ev.flag) begin
                    if (light_allowed())
                        enter_mode(MODE_ON);
                end else if (held_q == '0) begin
                    enter_mode(MODE_OFF);
                end
            end
            OP_RESET_USER: begin
                if (forced_q) begin
                    forced_q = 1'b0;
                    if (held_q == '0)
                        enter_mode(MODE_OFF);
                end
            end
            OP_RESET_TIMED: begin
                if (forced_q) begin
                    forced_q = 1'b0;
                    if (light_allowed())
                        enter_mode(MODE_TIMED);
                end
            end
            OP_TOGGLE_ENABLE: begin
                enabled_q = !enabled_q;
                enter_mode(light_allowed() ? MODE_TIMED : MODE_OFF);
            end
            OP_TOGGLE_AMBIENT: begin
                gate_q = !gate_q;
                enter_mode((light_allowed() && !bright_now) ? MODE_TIMED : MODE_OFF);
            end
            OP_ALLOW: begin
                if (permitted_q && !ev.flag)
                    enter_mode(MODE_OFF);
                permitted_q = ev.flag;
            end
            OP_TICK: begin
                if (countdown_q != '0) begin
                    countdown_q = countdown_q - 1'b1;
                    if (countdown_q == '0)
                        enter_mode(MODE_FADING);
                end
            end
            OP_SAMPLE: begin
                for (int i = P_WINDOW_DEPTH - 1; i > 0; i--)
                    window_q[i] = window_q[i-1];
                window_q[0] = ev.ambient_level;
                if (fill_q < P_WINDOW_DEPTH)
                    fill_q++;
            end
            default: ;
        endcase
        exp.brightness    = level_q;
        exp.mode          = mode_q;
        exp.level_changed = (level_q != prior);
        exp.count_error   = err;
        expected_levels.push_back(exp);
    endfunction

    function void check_level(t_result got);
        t_result exp;
        if (expected_levels.size() == 0) begin
            $error("result beat with nothing expected: brightness %0d mode %0d",
                   got.brightness, got.mode);
            errors++;
            return;
        end
        exp = expected_levels.pop_front();
        if (got.brightness !== exp.brightness) begin
            $error("brightness: expected %0d, got %0d", exp.brightness, got.brightness);
            errors++;
        end
        if (got.mode !== exp.mode) begin
            $error("mode: expected %0d, got %0d", exp.mode, got.mode);
            errors++;
        end
        if (got.level_changed !== exp.level_changed) begin
            $error("level_changed: expected %0d, got %0d",
                   exp.level_changed, got.level_changed);
            errors++;
        end
        if (got.count_error !== exp.count_error) begin
            $error("count_error: expected %0d, got %0d", exp.count_error, got.count_error);
            errors++;
        end
    endfunction

endclass

module tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [W_OPCODE-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [W_OPCODE-1:0] OP_SPARE_HI = 4'd15;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [W_CFG_IDX-1:0]  i_cfg_idx;
    logic [W_CFG_DATA-1:0] i_cfg_data;

    bfc_item_if   item_ch ();
    bfc_result_if res_ch ();

    fade_scoreboard sb = new();

    int items_sent  = 0;
    int burst_left  = 0;
    bit calm        = 1'b0;
    bit long_hold_req = 1'b0;

    backlight_fade_controller_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // observe both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        event_item_t ev;
        t_result     got;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                ev.opcode         = item_ch.opcode;
                ev.flag           = item_ch.flag;
                ev.ambient_bright = item_ch.ambient_bright;
                ev.power_save     = item_ch.power_save;
                ev.ambient_level  = item_ch.ambient_level;
                sb.note_event(ev);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.brightness    = res_ch.brightness;
                got.mode          = res_ch.mode;
                got.level_changed = res_ch.level_changed;
                got.count_error   = res_ch.count_error;
                sb.check_level(got);
            end
        end
    end

    // end the run when nothing moves on either channel for too long
    initial begin : watchdog
        int stale;
        stale = 0;
        while (stale < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                stale = 0;
            else
                stale++;
        end
        $display("backlight_fade_controller_unit verification failed");
        $finish;
    end

    // result receiver: random stall runs, one long hold-off on request
    initial begin : result_sink
        int run;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (calm) begin
                res_ch.ready = 1'b1;
            end else begin
                run = $urandom_range(1, 12);
                res_ch.ready = ($urandom_range(0, 3) != 0);
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    function automatic event_item_t beat_of(logic [W_OPCODE-1:0] op, bit flag, bit bright,
                                            bit power_save, logic [W_LEVEL-1:0] lvl);
        event_item_t ev;
        ev.opcode         = op;
        ev.flag           = flag;
        ev.ambient_bright = bright;
        ev.power_save     = power_save;
        ev.ambient_level  = lvl;
        return ev;
    endfunction

    // half the samples land right around the dark zone limit
    function automatic logic [W_LEVEL-1:0] sample_value();
        if ($urandom_range(0, 1) != 0)
            return W_LEVEL'($urandom);
        return sb.dark_limit + W_LEVEL'($urandom_range(0, 6)) - W_LEVEL'(3);
    endfunction

    function automatic event_item_t noise_beat();
        int                  pick;
        logic [W_OPCODE-1:0] op;
        bit                  flag;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_TICK;
        else if (pick < 42) op = OP_PRESS;
        else if (pick < 56) op = OP_RELEASE;
        else if (pick < 64) op = OP_INTERACT;
        else if (pick < 74) op = OP_SAMPLE;
        else if (pick < 78) op = OP_FORCE;
        else if (pick < 82) op = OP_REQUEST;
        else if (pick < 85) op = OP_RESET_USER;
        else if (pick < 88) op = OP_RESET_TIMED;
        else if (pick < 90) op = OP_TOGGLE_ENABLE;
        else if (pick < 92) op = OP_TOGGLE_AMBIENT;
        else if (pick < 97) op = OP_ALLOW;
        else                op = W_OPCODE'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        flag = (op == OP_ALLOW) ? ($urandom_range(0, 9) != 0) : 1'($urandom);
        return beat_of(op, flag, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0,
                       sample_value());
    endfunction

    // present one beat and hold it until accepted
    task automatic send_item(input event_item_t ev);
        @(negedge i_clk);
        item_ch.valid          = 1'b1;
        item_ch.opcode         = ev.opcode;
        item_ch.flag           = ev.flag;
        item_ch.ambient_bright = ev.ambient_bright;
        item_ch.power_save     = ev.power_save;
        item_ch.ambient_level  = ev.ambient_level;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // sender bursts with random gaps in between
    task automatic offer(input event_item_t ev);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!calm)
                pause($urandom_range(0, 10));
        end
        burst_left--;
        send_item(ev);
    endtask

    // stop offering and wait until every owed beat is back
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [W_CFG_DATA-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_cfg(idx, data);
    endtask

    task automatic setup(input logic [W_LEVEL-1:0] lvl, input logic [W_HOLD-1:0] hold,
                         input logic [W_INTERVAL-1:0] fade, input bit dyn,
                         input logic [W_LEVEL-1:0] dark);
        settle();
        write_reg(CFG_USER_LEVEL, W_CFG_DATA'(lvl));
        write_reg(CFG_HOLD_TICKS, W_CFG_DATA'(hold));
        write_reg(CFG_FADE_INTERVAL, W_CFG_DATA'(fade));
        write_reg(CFG_DYNAMIC_MODE, W_CFG_DATA'(dyn));
        write_reg(CFG_DARK_LIMIT, W_CFG_DATA'(dark));
    endtask

    // optional allow, samples, press, noise, release, then ticks to run the timer and the fade
    task automatic episode();
        bit lp;
        lp = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0)
            offer(beat_of(OP_ALLOW, 1'b1, 1'b0, lp, W_LEVEL'($urandom)));
        repeat ($urandom_range(0, 5))
            offer(beat_of(OP_SAMPLE, 1'($urandom), 1'b0, lp, sample_value()));
        offer(beat_of(OP_PRESS, 1'($urandom), $urandom_range(0, 3) == 0, lp,
                      W_LEVEL'($urandom)));
        repeat ($urandom_range(0, 2))
            offer(noise_beat());
        offer(beat_of(OP_RELEASE, 1'($urandom), 1'($urandom), lp, W_LEVEL'($urandom)));
        repeat ($urandom_range(1, 60))
            offer(beat_of(OP_TICK, 1'($urandom), $urandom_range(0, 3) == 0, lp,
                          W_LEVEL'($urandom)));
        if ($urandom_range(0, 3) == 0)
            offer(beat_of(OP_INTERACT, 1'($urandom), 1'($urandom), lp, W_LEVEL'($urandom)));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                episode();
            else
                repeat ($urandom_range(1, 8)) offer(noise_beat());
        end
    endtask

    initial begin : stimulus
        event_item_t directed [$];
        int          fails;

        // everything known from time zero, reset held for a while
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        item_ch.valid          = 1'b0;
        item_ch.opcode         = '0;
        item_ch.flag           = 1'b0;
        item_ch.ambient_bright = 1'b0;
        item_ch.power_save     = 1'b0;
        item_ch.ambient_level  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk through the states and corner cases
        setup(16'hFFFF, 20'd2, 8'd1, 1'b1, 16'd1000);
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));       // not yet allowed
        directed.push_back(beat_of(OP_RELEASE, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_RELEASE, 0, 0, 0, 16'h0000));     // release with none held
        directed.push_back(beat_of(OP_ALLOW, 1, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));       // empty window, user level
        directed.push_back(beat_of(OP_SAMPLE, 0, 0, 0, 16'hFFFF));
        directed.push_back(beat_of(OP_RELEASE, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_SAMPLE, 1, 1, 1, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 0, 1, 16'h0000));       // power save level
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 0, 0, 16'h0000));       // count overflow
        directed.push_back(beat_of(OP_FORCE, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_INTERACT, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_TICK, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_TICK, 0, 0, 0, 16'h0000));        // fade begins
        directed.push_back(beat_of(OP_TICK, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_REQUEST, 1, 1, 0, 16'h0000));
        directed.push_back(beat_of(OP_RESET_TIMED, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_TOGGLE_AMBIENT, 0, 1, 0, 16'h0000));
        directed.push_back(beat_of(OP_PRESS, 0, 1, 0, 16'h0000));       // gated by bright light
        directed.push_back(beat_of(OP_TOGGLE_AMBIENT, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_TOGGLE_ENABLE, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_TOGGLE_ENABLE, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_FORCE, 1, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_RESET_USER, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_ALLOW, 0, 0, 0, 16'h0000));
        directed.push_back(beat_of(OP_SPARE_LO, 1, 1, 1, 16'h5A5A));
        directed.push_back(beat_of(OP_SPARE_HI, 0, 0, 0, 16'hA5A5));
        foreach (directed[i])
            send_item(directed[i]);

        // full user level, short timer, fastest fade
        setup(16'hFFFF, 20'd3, 8'd1, 1'b0, 16'h0000);
        run_random(200);

        // zero user level, slowest fade, every sample dark
        setup(16'h0000, 20'd1, 8'd255, 1'b1, 16'hFFFF);
        run_random(150);

        // zero timing registers behave as one
        setup(W_LEVEL'($urandom), 20'd0, 8'd0, 1'b1, W_LEVEL'($urandom));
        run_random(200);

        // longest timer, no idling on either side
        calm = 1'b1;
        setup(W_LEVEL'($urandom), 20'hFFFFF, 8'd255, 1'b0, W_LEVEL'($urandom));
        run_random(150);

        // receiver holds off while the sender keeps offering
        setup(W_LEVEL'($urandom), W_HOLD'($urandom_range(1, 6)),
              W_INTERVAL'($urandom_range(1, 3)), 1'($urandom), W_LEVEL'($urandom));
        long_hold_req = 1'b1;
        repeat (30) offer(noise_beat());
        calm = 1'b0;
        run_random(300);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fails = sb.errors;
        if (sb.outstanding() != 0) begin
            $error("%0d expected result beats never arrived", sb.outstanding());
            fails++;
        end
        if (fails == 0)
            $display("backlight_fade_controller_unit verification clean");
        else
            $display("backlight_fade_controller_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bfc_pkg.sv
rtl/core/bfc_item_if.sv
rtl/core/bfc_result_if.sv
rtl/core/bfc_window.sv
rtl/core/bfc_fsm.sv
rtl/core/backlight_fade_controller_unit.sv
tb/tb.sv
